// ===== hdl/salru_pkg.sv =====
// Package for the set-associative LRU cache tag controller.
// Holds command codes, field widths and the state machine type.
// No dependencies.
package salru_pkg;

    localparam int CMD_W = 2;
    localparam int ADDR_W = 32;
    localparam int CNT_W = 32;
    localparam int WAY_OUT_W = 2;

    typedef enum logic [1:0]
    {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_FETCH = 2'd2,
        CMD_BAD   = 2'd3
    } cmd_t;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_LOOKUP,
        ST_OUT
    } state_t;

endpackage

// ===== hdl/salru_if.sv =====
// Valid/ready channel interfaces for the cache tag controller.
// Depends on salru_pkg.
interface salru_req_if
    import salru_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    command;
    logic [ADDR_W-1:0]   address;
    modport source (output valid, command, address, input ready);
    modport sink (input valid, command, address, output ready);
endinterface

interface salru_rsp_if
    import salru_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic                 hit;
    logic [WAY_OUT_W-1:0] way;
    logic                 writeback;
    logic [CNT_W-1:0]     access_count;
    logic [CNT_W-1:0]     hit_count;
    logic [CNT_W-1:0]     miss_count;
    logic [CNT_W-1:0]     read_count;
    logic [CNT_W-1:0]     write_count;
    logic [CNT_W-1:0]     writeback_count;
    modport source (output valid, hit, way, writeback, access_count, hit_count, miss_count,
        read_count, write_count, writeback_count, input ready);
    modport sink (input valid, hit, way, writeback, access_count, hit_count, miss_count,
        read_count, write_count, writeback_count, output ready);
endinterface

// ===== hdl/salru_ram.sv =====
// Generic single-port-write, one-read synchronous RAM with registered read.
// No dependencies.
module salru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== hdl/salru_stats.sv =====
// Statistics counters of the cache tag controller.
// Depends on salru_pkg.
module salru_stats
    import salru_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             upd,
    input  logic             is_valid_cmd,
    input  logic             is_write,
    input  logic             is_hit,
    input  logic             is_wb,
    output logic [CNT_W-1:0] access_count,
    output logic [CNT_W-1:0] hit_count,
    output logic [CNT_W-1:0] miss_count,
    output logic [CNT_W-1:0] read_count,
    output logic [CNT_W-1:0] write_count,
    output logic [CNT_W-1:0] writeback_count
);
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            access_count <= '0;
            hit_count <= '0;
            miss_count <= '0;
            read_count <= '0;
            write_count <= '0;
            writeback_count <= '0;
        end
        else if (upd)
        begin
            access_count <= access_count + 1'b1;
            if (is_valid_cmd)
            begin
                if (is_write)
                begin
                    write_count <= write_count + 1'b1;
                end
                else
                begin
                    read_count <= read_count + 1'b1;
                end
                if (is_hit)
                begin
                    hit_count <= hit_count + 1'b1;
                end
                else
                begin
                    miss_count <= miss_count + 1'b1;
                end
                if (is_wb)
                begin
                    writeback_count <= writeback_count + 1'b1;
                end
            end
        end
    end
endmodule

// ===== hdl/set_assoc_lru_cache_tags_core.sv =====
// Cache tag controller top level: set memories, lookup and LRU update.
// A request is accepted in idle, which also starts the set read; the set is updated by a
// read-modify-write in the lookup state, then the response is held until taken. No new request is accepted until then.
// Reset clears valid bits by a pass over all sets before requests are taken.
// Depends on salru_pkg, salru_if, salru_ram and salru_stats.
module set_assoc_lru_cache_tags_core
    import salru_pkg::*;
#(
    parameter int SETS = 64,
    parameter int WAYS = 4,
    parameter int LINE_BYTES = 64,
    parameter int ADDR_BITS = 32
) (
    input logic        clk,
    input logic        rst_n,
    salru_req_if.sink  req,
    salru_rsp_if.source rsp
);
    localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int OFF_W = $clog2(LINE_BYTES);
    localparam int ABITS = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
    localparam int SB = (SETS > 1) ? $clog2(SETS) : 0;
    localparam int TAG_W = (ABITS - OFF_W - SB > 0) ? ABITS - OFF_W - SB : 1;
    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int META_W = WAYS * (2 + WAY_W);

    state_t state_reg, state_next;
    logic [SET_W:0] clr_reg;
    logic clearing;
    logic [CMD_W-1:0] cmd_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [ABITS-1:0] a;
    logic [SET_W-1:0] set_idx;
    logic [SET_W-1:0] req_set;
    logic [SET_W-1:0] rd_set;
    logic [TAG_W-1:0] tag;
    logic [WAYS*TAG_W-1:0] tag_rd, tag_wd;
    logic [META_W-1:0] meta_rd, meta_wd;
    logic [WAYS-1:0] vld, drt, match, vld_n, drt_n;
    logic [WAY_W-1:0] rnk [WAYS];
    logic [WAY_W-1:0] rnk_n [WAYS];
    logic hit_c, free_c, wb_c, valid_cmd, is_wr, upd;
    logic [WAY_W-1:0] way_c, old_r;
    logic hit_reg, wb_reg;
    logic [WAY_W-1:0] way_reg;
    logic tag_we, meta_we;
    logic [SET_W-1:0] waddr;

    assign clearing = !clr_reg[SET_W];
    assign a = addr_reg[ABITS-1:0];
    if (SETS > 1)
    begin : g_set
        assign set_idx = a[OFF_W +: SET_W];
        assign req_set = req.address[OFF_W +: SET_W];
    end
    else
    begin : g_noset
        assign set_idx = '0;
        assign req_set = '0;
    end
    if (ABITS - OFF_W - SB > 0)
    begin : g_tag
        assign tag = a[ABITS-1 -: TAG_W];
    end
    else
    begin : g_notag
        assign tag = '0;
    end

    assign rd_set = (state_reg == ST_IDLE) ? req_set : set_idx;

    salru_ram #(.WIDTH(WAYS*TAG_W), .DEPTH(SETS)) u_tags (
        .clk(clk), .we(tag_we), .waddr(waddr), .wdata(tag_wd),
        .raddr(rd_set), .rdata(tag_rd));
    salru_ram #(.WIDTH(META_W), .DEPTH(SETS)) u_meta (
        .clk(clk), .we(meta_we), .waddr(waddr), .wdata(meta_wd),
        .raddr(rd_set), .rdata(meta_rd));

    assign valid_cmd = cmd_t'(cmd_reg) != CMD_BAD;
    assign is_wr = cmd_t'(cmd_reg) == CMD_WRITE;

    always_comb
    begin
        hit_c = 1'b0;
        free_c = 1'b0;
        way_c = '0;
        wb_c = 1'b0;
        old_r = '0;
        for (int i = 0; i < WAYS; i++)
        begin
            vld[i] = meta_rd[i*(2+WAY_W)];
            drt[i] = meta_rd[i*(2+WAY_W)+1];
            rnk[i] = meta_rd[i*(2+WAY_W)+2 +: WAY_W];
            match[i] = vld[i] && (tag_rd[i*TAG_W +: TAG_W] == tag);
        end
        for (int i = WAYS-1; i >= 0; i--)
        begin
            if (match[i])
            begin
                hit_c = 1'b1;
                way_c = WAY_W'(i);
            end
        end
        if (!hit_c)
        begin
            for (int i = WAYS-1; i >= 0; i--)
            begin
                if (!vld[i])
                begin
                    free_c = 1'b1;
                    way_c = WAY_W'(i);
                end
            end
            if (!free_c)
            begin
                for (int i = 0; i < WAYS; i++)
                begin
                    if (rnk[i] == WAY_W'(WAYS-1))
                    begin
                        way_c = WAY_W'(i);
                    end
                end
                wb_c = drt[way_c];
            end
        end
        for (int i = 0; i < WAYS; i++)
        begin
            vld_n[i] = vld[i];
            drt_n[i] = drt[i];
            rnk_n[i] = rnk[i];
            if (vld[i] && i == int'(way_c))
            begin
                old_r = rnk[i];
            end
        end
        for (int i = 0; i < WAYS; i++)
        begin
            if (i == int'(way_c))
            begin
                rnk_n[i] = '0;
                vld_n[i] = 1'b1;
                drt_n[i] = hit_c ? (drt[i] | is_wr) : is_wr;
            end
            else if (vld[i] && (!vld[way_c] || rnk[i] < old_r))
            begin
                rnk_n[i] = rnk[i] + 1'b1;
            end
        end
        for (int i = 0; i < WAYS; i++)
        begin
            meta_wd[i*(2+WAY_W)] = clearing ? 1'b0 : vld_n[i];
            meta_wd[i*(2+WAY_W)+1] = clearing ? 1'b0 : drt_n[i];
            meta_wd[i*(2+WAY_W)+2 +: WAY_W] = clearing ? '0 : rnk_n[i];
            tag_wd[i*TAG_W +: TAG_W] = (i == int'(way_c)) ? tag : tag_rd[i*TAG_W +: TAG_W];
        end
    end

    assign upd = (state_reg == ST_LOOKUP);
    assign meta_we = clearing || (upd && valid_cmd);
    assign tag_we = upd && valid_cmd && !hit_c;
    assign waddr = clearing ? clr_reg[SET_W-1:0] : set_idx;

    always_comb
    begin
        state_next = state_reg;
        req.ready = 1'b0;
        rsp.valid = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req.ready = !clearing;
                if (req.valid && !clearing)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                rsp.valid = 1'b1;
                if (rsp.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            clr_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (clearing)
            begin
                clr_reg <= (clr_reg[SET_W-1:0] == SET_W'(SETS-1)) ?
                    {1'b1, {SET_W{1'b0}}} : clr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            cmd_reg <= req.command;
            addr_reg <= req.address;
        end
        if (upd)
        begin
            hit_reg <= valid_cmd && hit_c;
            wb_reg <= valid_cmd && wb_c;
            way_reg <= valid_cmd ? way_c : '0;
        end
    end

    salru_stats u_stats (
        .clk(clk), .rst_n(rst_n), .upd(upd), .is_valid_cmd(valid_cmd), .is_write(is_wr),
        .is_hit(hit_c), .is_wb(wb_c),
        .access_count(rsp.access_count), .hit_count(rsp.hit_count),
        .miss_count(rsp.miss_count), .read_count(rsp.read_count),
        .write_count(rsp.write_count), .writeback_count(rsp.writeback_count));

    assign rsp.hit = hit_reg;
    assign rsp.writeback = wb_reg;
    assign rsp.way = WAY_OUT_W'(way_reg);

    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !req.ready)
        else $error("request accepted during clear pass");
    a_hit_no_wb: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !(rsp.hit && rsp.writeback))
        else $error("writeback reported on a hit");
    a_lookup_next: assert property (@(posedge clk) disable iff (!rst_n)
        upd |=> state_reg == ST_OUT)
        else $error("lookup not followed by response");
endmodule

// ===== dv/set_assoc_lru_cache_tags_test_if.sv =====
`timescale 1ns / 100ps
// Testbench side of the cache tag controller channels.
// The block's own interfaces live in hdl/salru_if.sv; this file only holds the result record.
// Depends on salru_pkg.
package salru_test_pkg;
    import salru_pkg::*;

    typedef struct packed
    {
        logic                 hit;
        logic [WAY_OUT_W-1:0] way;
        logic                 writeback;
        logic [CNT_W-1:0]     access_count;
        logic [CNT_W-1:0]     hit_count;
        logic [CNT_W-1:0]     miss_count;
        logic [CNT_W-1:0]     read_count;
        logic [CNT_W-1:0]     write_count;
        logic [CNT_W-1:0]     writeback_count;
    } lookup_result_t;
endpackage

// ===== dv/set_assoc_lru_cache_tags_core_test.sv =====
`timescale 1ns / 100ps
// Testbench for set_assoc_lru_cache_tags_core: directed and random cache references,
// predicted by an LRU tag model in a scoreboard class and checked field by field.
// Depends on salru_pkg, salru_if, salru_test_pkg and the block's RTL.
module set_assoc_lru_cache_tags_core_test;
    import salru_pkg::*;
    import salru_test_pkg::*;

    localparam int NSETS = 64;
    localparam int NWAYS = 4;
    localparam int LINE = 64;

    class lru_tag_scoreboard;
        logic [25:0] tags [NSETS][NWAYS];
        bit valid [NSETS][NWAYS];
        bit dirty [NSETS][NWAYS];
        int rank [NSETS][NWAYS];
        lookup_result_t totals;
        lookup_result_t pending [$];
        int errors;

        function void clear();
            foreach (valid[s, w])
            begin
                valid[s][w] = 0;
                dirty[s][w] = 0;
                rank[s][w] = 0;
                tags[s][w] = '0;
            end
            totals = '0;
            errors = 0;
            pending.delete();
        endfunction

        function void promote(int s, int w);
            int old;
            old = valid[s][w] ? rank[s][w] : NWAYS;
            for (int i = 0; i < NWAYS; i++)
                if (i != w && valid[s][i] && rank[s][i] < old)
                    rank[s][i]++;
            rank[s][w] = 0;
        endfunction

        function void note_request(cmd_t cmd, logic [31:0] addr);
            int s;
            int w;
            int best;
            bit found;
            logic [25:0] tag;
            s = (addr / LINE) % NSETS;
            tag = 26'(addr / (LINE * NSETS));
            totals.hit = 0;
            totals.way = 0;
            totals.writeback = 0;
            totals.access_count++;
            if (cmd != CMD_BAD)
            begin
                if (cmd == CMD_WRITE)
                    totals.write_count++;
                else
                    totals.read_count++;
                found = 0;
                w = 0;
                for (int i = 0; i < NWAYS; i++)
                    if (!found && valid[s][i] && tags[s][i] == tag)
                    begin
                        found = 1;
                        w = i;
                    end
                if (found)
                begin
                    totals.hit = 1;
                    totals.hit_count++;
                    if (cmd == CMD_WRITE)
                        dirty[s][w] = 1;
                    promote(s, w);
                end
                else
                begin
                    totals.miss_count++;
                    for (int i = NWAYS - 1; i >= 0; i--)
                        if (!valid[s][i])
                        begin
                            found = 1;
                            w = i;
                        end
                    if (!found)
                    begin
                        best = 0;
                        for (int i = 0; i < NWAYS; i++)
                            if (rank[s][i] > best)
                            begin
                                best = rank[s][i];
                                w = i;
                            end
                        if (dirty[s][w])
                        begin
                            totals.writeback = 1;
                            totals.writeback_count++;
                        end
                    end
                    promote(s, w);
                    valid[s][w] = 1;
                    dirty[s][w] = (cmd == CMD_WRITE);
                    tags[s][w] = tag;
                end
                totals.way = WAY_OUT_W'(w);
            end
            pending.push_back(totals);
        endfunction

        function void check_result(lookup_result_t got);
            lookup_result_t exp;
            if (pending.size() == 0)
            begin
                $display("%0t: result with nothing expected, actual %p", $time, got);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.hit !== exp.hit || got.way !== exp.way || got.writeback !== exp.writeback
                || got.access_count !== exp.access_count || got.hit_count !== exp.hit_count
                || got.miss_count !== exp.miss_count || got.read_count !== exp.read_count
                || got.write_count !== exp.write_count
                || got.writeback_count !== exp.writeback_count)
            begin
                $display("%0t: mismatch, expected %p, actual %p", $time, exp, got);
                errors++;
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    int send_idle = 0;
    int recv_idle = 0;
    lru_tag_scoreboard board;

    salru_req_if req ();
    salru_rsp_if rsp ();

    set_assoc_lru_cache_tags_core dut (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

    always #5 clk = ~clk;

    initial
    begin
        req.valid = 0;
        req.command = '0;
        req.address = '0;
        rsp.ready = 0;
    end

    always @(negedge clk)
        rsp.ready <= ($urandom_range(99) >= recv_idle);

    always @(posedge clk)
        if (rst_n && rsp.valid && rsp.ready)
            board.check_result({rsp.hit, rsp.way, rsp.writeback, rsp.access_count,
                rsp.hit_count, rsp.miss_count, rsp.read_count, rsp.write_count,
                rsp.writeback_count});

    task automatic send_reference(cmd_t cmd, logic [31:0] addr);
        while ($urandom_range(99) < send_idle)
        begin
            req.valid <= 0;
            @(negedge clk);
        end
        req.valid <= 1;
        req.command <= cmd;
        req.address <= addr;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        board.note_request(cmd, addr);
        @(negedge clk);
    endtask

    function automatic logic [31:0] pick_address(int hot_tags);
        logic [31:0] a;
        a = $urandom;
        if ($urandom_range(9) < 8)
            a[31:12] = 20'($urandom_range(hot_tags - 1) << ($urandom_range(1) ? 0 : 14));
        if ($urandom_range(3) != 0)
            a[11:6] = 6'($urandom_range(3));
        return a;
    endfunction

    task automatic run_random(int count);
        cmd_t cmd;
        for (int i = 0; i < count; i++)
        begin
            cmd = cmd_t'($urandom_range(9) == 0 ? 3 : $urandom_range(2));
            send_reference(cmd, pick_address(8));
        end
    endtask

    initial
    begin
        board = new();
        board.clear();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        send_reference(CMD_READ, 32'h0000_0000);
        send_reference(CMD_READ, 32'h0000_0000);
        send_reference(CMD_WRITE, 32'hFFFF_FFFF);
        send_reference(CMD_FETCH, 32'hFFFF_FFC0);
        send_reference(CMD_BAD, 32'h1234_5678);
        for (int t = 0; t < 6; t++)
            send_reference(t % 2 ? CMD_WRITE : CMD_READ, 32'h0000_1040 + t * 32'h1000);
        send_reference(CMD_WRITE, 32'h0000_3040);
        for (int t = 0; t < 5; t++)
            send_reference(CMD_FETCH, 32'h0010_0040 + t * 32'h1000);
        send_reference(CMD_WRITE, 32'hAAAA_A5AA);
        send_reference(CMD_READ, 32'h5555_5A55);
        send_idle = 26;
        recv_idle = 81;
        run_random(180);
        send_idle = 81;
        recv_idle = 26;
        run_random(180);
        send_idle = 0;
        recv_idle = 0;
        run_random(180);
        req.valid <= 0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (board.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end
endmodule
